// File: sv/iprd_pkg.sv
// Shared types and constants for the image-plane ray direction block.
// No dependencies; every other file imports this package.
package iprd_pkg;

    // Fixed-point geometry
    localparam int Q_FRAC = 30;             // fraction bits of a unit component
    localparam int MAG_W  = 30;             // block-scaled magnitude width
    localparam int SQ_W   = 64;             // sum of squares and remainders
    localparam int ROOT_W = 31;             // integer square root width
    localparam int QUO_W  = 32;             // quotient width of the divide chain
    localparam int DIR_W  = 32;             // Q1.30 output component width
    localparam int MUL_LO = 15;             // low split of the mapping multiply

    // Configuration register indexes
    localparam int                CIDX_W    = 2;
    localparam logic [CIDX_W-1:0] CFG_OBS_X = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_OBS_Y = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_OBS_Z = 2'd2;

    // Observer X reset value, 215.0 in Q16.16, widest coordinate format
    localparam logic [47:0] OBS_X_RESET = 48'd14090240;

    // Sideband that travels with each vector through a pipeline
    typedef struct packed {
        logic       vld;
        logic       deg;
        logic [2:0] neg;
    } t_side;

endpackage

// File: sv/iprd_sqrt_cell.sv
// One cell of the integer square root chain: decides one root bit.
// Depends on iprd_pkg.
module iprd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic [iprd_pkg::SQ_W-1:0]              i_rem,
    input  logic [iprd_pkg::ROOT_W-1:0]            i_root,
    input  logic [2:0][iprd_pkg::MAG_W-1:0]        i_m,
    input  iprd_pkg::t_side                        i_side,
    output logic [iprd_pkg::SQ_W-1:0]              o_rem,
    output logic [iprd_pkg::ROOT_W-1:0]            o_root,
    output logic [2:0][iprd_pkg::MAG_W-1:0]        o_m,
    output iprd_pkg::t_side                        o_side
);
    import iprd_pkg::*;

    logic [SQ_W-1:0]          trial;
    logic                     take;
    logic [SQ_W-1:0]          n_rem;
    logic [ROOT_W-1:0]        n_root;
    logic [SQ_W-1:0]          r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [2:0][MAG_W-1:0]    r_m;
    t_side                    r_side;

    // Trial subtrahend (2*root + 2^K) * 2^K, root holding only bits above K
    assign trial  = (SQ_W'({i_root, 1'b0}) + (SQ_W'(1) << K)) << K;
    assign take   = (i_rem >= trial);
    assign n_rem  = take ? (i_rem - trial) : i_rem;
    assign n_root = take ? (i_root | (ROOT_W'(1) << K)) : i_root;

    // Advance the cell when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_m    <= i_m;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_m    = r_m;
    assign o_side = r_side;

endmodule

// File: sv/iprd_div_cell.sv
// One cell of the three-lane restoring divide chain: one quotient bit per lane.
// Depends on iprd_pkg.
module iprd_div_cell #(
    parameter int K = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic [iprd_pkg::ROOT_W-1:0]            i_len,
    input  logic [2:0][iprd_pkg::SQ_W-1:0]         i_rem,
    input  logic [2:0][iprd_pkg::QUO_W-1:0]        i_q,
    input  iprd_pkg::t_side                        i_side,
    output logic [iprd_pkg::ROOT_W-1:0]            o_len,
    output logic [2:0][iprd_pkg::SQ_W-1:0]         o_rem,
    output logic [2:0][iprd_pkg::QUO_W-1:0]        o_q,
    output iprd_pkg::t_side                        o_side
);
    import iprd_pkg::*;

    logic [SQ_W-1:0]          dsr;
    logic [2:0][SQ_W-1:0]     n_rem;
    logic [2:0][QUO_W-1:0]    n_q;
    logic [ROOT_W-1:0]        r_len;
    logic [2:0][SQ_W-1:0]     r_rem;
    logic [2:0][QUO_W-1:0]    r_q;
    t_side                    r_side;

    assign dsr = SQ_W'(i_len) << K;

    // Subtract the shifted divisor where it fits, lane by lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_rem[i] >= dsr) begin
                n_rem[i] = i_rem[i] - dsr;
                n_q[i]   = i_q[i] | (QUO_W'(1) << K);
            end else begin
                n_rem[i] = i_rem[i];
                n_q[i]   = i_q[i];
            end
        end
    end

    // Advance the cell when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else if (i_en) begin
            r_len  <= i_len;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_len  = r_len;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

// File: sv/iprd_norm.sv
// Vector normalizer: block scaling, sum of squares, square root chain and
// divide chain into a Q1.30 unit vector. Depends on iprd_pkg and the cells.
module iprd_norm #(
    parameter int VW = 33
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic [2:0][VW-1:0]                     i_v,
    input  iprd_pkg::t_side                        i_side,
    output logic [2:0][iprd_pkg::DIR_W-1:0]        o_dir,
    output iprd_pkg::t_side                        o_side
);
    import iprd_pkg::*;

    localparam int NW  = (VW > MAG_W) ? VW : MAG_W;
    localparam int SHS = $clog2(NW);

    logic [2:0][VW-1:0]       abs_v;
    logic [2:0][NW-1:0]       n_mag0;
    logic [2:0]               n_neg0;
    logic [2:0][NW-1:0]       r_sh [SHS+1];
    t_side                    r_shs [SHS+1];

    logic [2:0][MAG_W-1:0]    n_mq;
    logic                     mq_zero;
    logic [2:0][MAG_W-1:0]    r_mq;
    t_side                    r_sq;
    logic [2:0][2*MAG_W-1:0]  r_sqr;
    logic [2:0][MAG_W-1:0]    r_ms;
    t_side                    r_ss;
    logic [SQ_W-1:0]          r_sum;
    logic [2:0][MAG_W-1:0]    r_mt;
    t_side                    r_ts;

    logic [SQ_W-1:0]          w_srem  [ROOT_W+1];
    logic [ROOT_W-1:0]        w_sroot [ROOT_W+1];
    logic [2:0][MAG_W-1:0]    w_sm    [ROOT_W+1];
    t_side                    w_ss    [ROOT_W+1];

    logic [ROOT_W-1:0]        r_dlen;
    logic [2:0][SQ_W-1:0]     r_drem;
    t_side                    r_ds;

    logic [ROOT_W-1:0]        w_len   [QUO_W+1];
    logic [2:0][SQ_W-1:0]     w_drem  [QUO_W+1];
    logic [2:0][QUO_W-1:0]    w_q     [QUO_W+1];
    t_side                    w_ds    [QUO_W+1];

    logic [2:0][DIR_W-1:0]    n_dir;
    logic [2:0][DIR_W-1:0]    r_dir;
    t_side                    r_fs;

    // Take magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg0[i] = i_v[i][VW-1];
            abs_v[i]  = n_neg0[i] ? (~i_v[i] + VW'(1)) : i_v[i];
            n_mag0[i] = NW'(abs_v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shs[0].vld <= 1'b0;
        end else if (i_en) begin
            r_sh[0]  <= n_mag0;
            r_shs[0] <= '{vld: i_side.vld, deg: i_side.deg, neg: n_neg0};
        end
    end

    // Left-align the common leading one, one power-of-two step per stage
    for (genvar j = 0; j < SHS; j++) begin : g_shift
        localparam int SA = 1 << (SHS - 1 - j);
        logic               top_zero;
        logic [2:0][NW-1:0] n_sh;

        assign top_zero = ~|(r_sh[j][0][NW-1 -: SA] | r_sh[j][1][NW-1 -: SA]
                             | r_sh[j][2][NW-1 -: SA]);

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_sh[i] = top_zero ? (r_sh[j][i] << SA) : r_sh[j][i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_shs[j+1].vld <= 1'b0;
            end else if (i_en) begin
                r_sh[j+1]  <= n_sh;
                r_shs[j+1] <= r_shs[j];
            end
        end
    end

    // Keep the top MAG_W bits: the largest magnitude now lies in [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mq[i] = r_sh[SHS][i][NW-1 -: MAG_W];
        end
    end
    assign mq_zero = (n_mq[0] == '0) && (n_mq[1] == '0) && (n_mq[2] == '0);

    // Extract, square, then sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
            r_ss.vld <= 1'b0;
            r_ts.vld <= 1'b0;
        end else if (i_en) begin
            r_mq     <= n_mq;
            r_sq     <= '{vld: r_shs[SHS].vld, deg: r_shs[SHS].deg | mq_zero,
                          neg: r_shs[SHS].neg};
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= (2*MAG_W)'(r_mq[i]) * (2*MAG_W)'(r_mq[i]);
            end
            r_ms     <= r_mq;
            r_ss     <= r_sq;
            r_sum    <= SQ_W'(r_sqr[0]) + SQ_W'(r_sqr[1]) + SQ_W'(r_sqr[2]);
            r_mt     <= r_ms;
            r_ts     <= r_ss;
        end
    end

    // Square root chain, most significant root bit first
    assign w_srem[0]  = r_sum;
    assign w_sroot[0] = '0;
    assign w_sm[0]    = r_mt;
    assign w_ss[0]    = r_ts;

    for (genvar c = 0; c < ROOT_W; c++) begin : g_sqrt
        iprd_sqrt_cell #(
            .K(ROOT_W - 1 - c)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_rem  (w_srem[c]),
            .i_root (w_sroot[c]),
            .i_m    (w_sm[c]),
            .i_side (w_ss[c]),
            .o_rem  (w_srem[c+1]),
            .o_root (w_sroot[c+1]),
            .o_m    (w_sm[c+1]),
            .o_side (w_ss[c+1])
        );
    end

    // Form the rounded dividends m * 2^30 + len / 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds.vld <= 1'b0;
        end else if (i_en) begin
            r_dlen <= w_sroot[ROOT_W];
            for (int i = 0; i < 3; i++) begin
                r_drem[i] <= (SQ_W'(w_sm[ROOT_W][i]) << Q_FRAC)
                             + SQ_W'(w_sroot[ROOT_W] >> 1);
            end
            r_ds <= w_ss[ROOT_W];
        end
    end

    // Divide chain, most significant quotient bit first
    assign w_len[0]  = r_dlen;
    assign w_drem[0] = r_drem;
    assign w_q[0]    = '0;
    assign w_ds[0]   = r_ds;

    for (genvar c = 0; c < QUO_W; c++) begin : g_div
        iprd_div_cell #(
            .K(QUO_W - 1 - c)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_len  (w_len[c]),
            .i_rem  (w_drem[c]),
            .i_q    (w_q[c]),
            .i_side (w_ds[c]),
            .o_len  (w_len[c+1]),
            .o_rem  (w_drem[c+1]),
            .o_q    (w_q[c+1]),
            .o_side (w_ds[c+1])
        );
    end

    // Restore signs, force zero on a degenerate vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_ds[QUO_W].deg) begin
                n_dir[i] = '0;
            end else if (w_ds[QUO_W].neg[i]) begin
                n_dir[i] = DIR_W'(~w_q[QUO_W][i] + QUO_W'(1));
            end else begin
                n_dir[i] = DIR_W'(w_q[QUO_W][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs.vld <= 1'b0;
        end else if (i_en) begin
            r_dir <= n_dir;
            r_fs  <= w_ds[QUO_W];
        end
    end

    assign o_dir  = r_dir;
    assign o_side = r_fs;

endmodule

// File: sv/iprd_basis.sv
// Image-plane basis: tau = norm(Z x obs), n = norm(obs), xi = n x tau.
// Depends on iprd_pkg and iprd_norm; recomputed on each start pulse.
module iprd_basis #(
    parameter int CB = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [2:0][CB-1:0]                     i_obs,
    output logic [2:0][iprd_pkg::DIR_W-1:0]        o_tau,
    output logic [2:0][iprd_pkg::DIR_W-1:0]        o_xi,
    output logic                                   o_deg,
    output logic                                   o_done
);
    import iprd_pkg::*;

    localparam int VW = CB + 1;

    logic [2:0][VW-1:0]       w_ext;
    logic [2:0][VW-1:0]       w_tv;
    t_side                    w_start_side;
    logic [2:0][DIR_W-1:0]    w_tau;
    logic [2:0][DIR_W-1:0]    w_n;
    t_side                    w_tau_side;
    t_side                    w_n_side;

    logic signed [63:0]       r_p [4];
    logic                     r_x1_vld;
    logic                     r_x1_deg;
    logic [2:0][DIR_W-1:0]    r_xi;
    logic                     r_x2_vld;
    logic                     r_x2_deg;

    function automatic logic [DIR_W-1:0] rnd_q60(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? (~x + 64'd1) : x;
        r = (m + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        rnd_q60 = x[63] ? (~r[DIR_W-1:0] + DIR_W'(1)) : r[DIR_W-1:0];
    endfunction

    // Tangent seed (-obs_y, obs_x, 0) and sign-extended observer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ext[i] = {i_obs[i][CB-1], i_obs[i]};
        end
    end
    assign w_tv[0] = ~w_ext[1] + VW'(1);
    assign w_tv[1] = w_ext[0];
    assign w_tv[2] = '0;
    assign w_start_side = '{vld: i_start, deg: 1'b0, neg: 3'b000};

    iprd_norm #(
        .VW(VW)
    ) u_tau_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (1'b1),
        .i_v    (w_tv),
        .i_side (w_start_side),
        .o_dir  (w_tau),
        .o_side (w_tau_side)
    );

    iprd_norm #(
        .VW(VW)
    ) u_n_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (1'b1),
        .i_v    (w_ext),
        .i_side (w_start_side),
        .o_dir  (w_n),
        .o_side (w_n_side)
    );

    // Cross product terms; tau has no Z component
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_vld <= 1'b0;
            r_x2_vld <= 1'b0;
        end else begin
            r_x1_vld <= w_tau_side.vld;
            r_x2_vld <= r_x1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0]   <= $signed(w_n[2]) * $signed(w_tau[1]);
        r_p[1]   <= $signed(w_n[2]) * $signed(w_tau[0]);
        r_p[2]   <= $signed(w_n[0]) * $signed(w_tau[1]);
        r_p[3]   <= $signed(w_n[1]) * $signed(w_tau[0]);
        r_x1_deg <= w_tau_side.deg | w_n_side.deg;
        r_xi[0]  <= rnd_q60(-r_p[0]);
        r_xi[1]  <= rnd_q60(r_p[1]);
        r_xi[2]  <= rnd_q60(r_p[2] - r_p[3]);
        r_x2_deg <= r_x1_deg;
    end

    assign o_tau  = w_tau;
    assign o_xi   = r_xi;
    assign o_deg  = r_x2_deg;
    assign o_done = r_x2_vld;

endmodule

// File: sv/iprd_map.sv
// Target mapping: slope = tau*target_tau + xi*target_xi - observer, with each
// product rounded to Q16.16. Depends on iprd_pkg.
module iprd_map #(
    parameter int CB = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic [CB-1:0]                          i_tau_t,
    input  logic [CB-1:0]                          i_xi_t,
    input  logic [2:0][iprd_pkg::DIR_W-1:0]        i_tau,
    input  logic [2:0][iprd_pkg::DIR_W-1:0]        i_xi,
    input  logic [2:0][CB-1:0]                     i_obs,
    input  logic                                   i_deg,
    output logic [2:0][CB+2:0]                     o_slope,
    output iprd_pkg::t_side                        o_side
);
    import iprd_pkg::*;

    localparam int SW = CB + 3;
    localparam int HW = CB - MUL_LO;
    localparam int PW = HW + DIR_W;
    localparam int LW = MUL_LO + DIR_W + 1;
    localparam int RW = PW + 1;

    logic [CB-1:0]            n_ma;
    logic [CB-1:0]            n_mb;
    logic [CB-1:0]            r_ma;
    logic [CB-1:0]            r_mb;
    logic                     r_na;
    logic                     r_nb;
    t_side                    r_s1;

    logic [2:0][DIR_W-1:0]    mt;
    logic [2:0][DIR_W-1:0]    mx;
    logic [2:0][PW-1:0]       r_pa;
    logic [2:0][PW-1:0]       r_pb;
    logic [2:0][LW-1:0]       r_la;
    logic [2:0][LW-1:0]       r_lb;
    logic [2:0]               r_sa;
    logic [2:0]               r_sb;
    t_side                    r_s2;

    logic [2:0][SW-1:0]       n_ra;
    logic [2:0][SW-1:0]       n_rb;
    logic [2:0][SW-1:0]       r_ra;
    logic [2:0][SW-1:0]       r_rb;
    t_side                    r_s3;

    logic [2:0][SW-1:0]       r_slope;
    t_side                    r_s4;

    // Target magnitudes and signs
    assign n_ma = i_tau_t[CB-1] ? (~i_tau_t + CB'(1)) : i_tau_t;
    assign n_mb = i_xi_t[CB-1]  ? (~i_xi_t + CB'(1))  : i_xi_t;

    // Basis magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mt[i] = i_tau[i][DIR_W-1] ? (~i_tau[i] + DIR_W'(1)) : i_tau[i];
            mx[i] = i_xi[i][DIR_W-1]  ? (~i_xi[i] + DIR_W'(1))  : i_xi[i];
        end
    end

    // Split products, ha * mt and la * mt + half, rounded in the next stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ra[i] = SW'((RW'(r_pa[i]) + RW'(r_la[i] >> MUL_LO)) >> MUL_LO);
            n_rb[i] = SW'((RW'(r_pb[i]) + RW'(r_lb[i] >> MUL_LO)) >> MUL_LO);
            if (r_sa[i]) begin
                n_ra[i] = ~n_ra[i] + SW'(1);
            end
            if (r_sb[i]) begin
                n_rb[i] = ~n_rb[i] + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
        end else if (i_en) begin
            // capture the request
            r_ma <= n_ma;
            r_mb <= n_mb;
            r_na <= i_tau_t[CB-1];
            r_nb <= i_xi_t[CB-1];
            r_s1 <= '{vld: i_vld, deg: i_deg, neg: 3'b000};
            // multiply
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= PW'(r_ma[CB-1:MUL_LO]) * PW'(mt[i]);
                r_pb[i] <= PW'(r_mb[CB-1:MUL_LO]) * PW'(mx[i]);
                r_la[i] <= LW'(r_ma[MUL_LO-1:0]) * LW'(mt[i])
                           + (LW'(1) << (Q_FRAC - 1));
                r_lb[i] <= LW'(r_mb[MUL_LO-1:0]) * LW'(mx[i])
                           + (LW'(1) << (Q_FRAC - 1));
                r_sa[i] <= r_na ^ i_tau[i][DIR_W-1];
                r_sb[i] <= r_nb ^ i_xi[i][DIR_W-1];
            end
            r_s2 <= r_s1;
            // round and sign
            r_ra <= n_ra;
            r_rb <= n_rb;
            r_s3 <= r_s2;
            // add and drop the observer
            for (int i = 0; i < 3; i++) begin
                r_slope[i] <= r_ra[i] + r_rb[i] - {{3{i_obs[i][CB-1]}}, i_obs[i]};
            end
            r_s4 <= r_s3;
        end
    end

    assign o_slope = r_slope;
    assign o_side  = r_s4;

endmodule

// File: sv/image_plane_ray_direction_top.sv
// Ray direction top: one request per cycle, unless a finished result is held or
// the basis recomputes, through the mapping stages, the 31-cell square root chain
// and the 32-cell divide chain. After reset and after each configuration write the
// basis is recomputed in a chain of the same form, while input and configuration
// ready stay low. Reset is synchronous; observer resets to (215, 0, 0).
module image_plane_ray_direction_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [COORD_BITS-1:0]                  i_target_tau,
    input  logic [COORD_BITS-1:0]                  i_target_xi,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [iprd_pkg::DIR_W-1:0]             o_dir_x,
    output logic [iprd_pkg::DIR_W-1:0]             o_dir_y,
    output logic [iprd_pkg::DIR_W-1:0]             o_dir_z,
    output logic                                   o_degenerate,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [iprd_pkg::CIDX_W-1:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0]                  i_cfg_data
);
    import iprd_pkg::*;

    localparam int CB = COORD_BITS;

    logic [2:0][CB-1:0]       r_obs;
    logic                     r_busy;
    logic                     r_start;
    logic                     w_cfg_acc;
    logic                     w_en;

    logic [2:0][DIR_W-1:0]    w_tau;
    logic [2:0][DIR_W-1:0]    w_xi;
    logic                     w_basis_deg;
    logic                     w_basis_done;

    logic [2:0][CB+2:0]       w_slope;
    t_side                    w_slope_side;
    logic [2:0][DIR_W-1:0]    w_dir;
    t_side                    w_out_side;

    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !r_busy;

    // Move the whole item pipeline unless a finished result is held
    assign w_en       = !w_out_side.vld || i_out_ready;
    assign o_in_ready = w_en && !r_busy;

    // Configuration registers and basis recompute control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs[0] <= OBS_X_RESET[CB-1:0];
            r_obs[1] <= '0;
            r_obs[2] <= '0;
            r_busy   <= 1'b1;
            r_start  <= 1'b1;
        end else begin
            r_start <= w_cfg_acc;
            if (w_cfg_acc) begin
                r_busy <= 1'b1;
                case (i_cfg_index)
                    CFG_OBS_X: r_obs[0] <= i_cfg_data;
                    CFG_OBS_Y: r_obs[1] <= i_cfg_data;
                    CFG_OBS_Z: r_obs[2] <= i_cfg_data;
                    default: ;
                endcase
            end else if (w_basis_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    iprd_basis #(
        .CB(CB)
    ) u_basis (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_obs  (r_obs),
        .o_tau  (w_tau),
        .o_xi   (w_xi),
        .o_deg  (w_basis_deg),
        .o_done (w_basis_done)
    );

    iprd_map #(
        .CB(CB)
    ) u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_in_valid && o_in_ready),
        .i_tau_t(i_target_tau),
        .i_xi_t (i_target_xi),
        .i_tau  (w_tau),
        .i_xi   (w_xi),
        .i_obs  (r_obs),
        .i_deg  (w_basis_deg),
        .o_slope(w_slope),
        .o_side (w_slope_side)
    );

    iprd_norm #(
        .VW(CB + 3)
    ) u_dir_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (w_slope),
        .i_side (w_slope_side),
        .o_dir  (w_dir),
        .o_side (w_out_side)
    );

    assign o_out_valid  = w_out_side.vld;
    assign o_dir_x      = w_dir[0];
    assign o_dir_y      = w_dir[1];
    assign o_dir_z      = w_dir[2];
    assign o_degenerate = w_out_side.deg;

    // A configuration write blocks requests until the basis settles
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_acc |=> (r_busy && !o_in_ready && !o_cfg_ready))
        else $error("request accepted while basis recomputes");

    // A degenerate result carries a zero direction
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
        (o_dir_x == '0 && o_dir_y == '0 && o_dir_z == '0))
        else $error("degenerate result with nonzero direction");

    // Basis completion releases the block
    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_basis_done && r_busy) |=> !r_busy)
        else $error("block stays busy after basis completion");

endmodule
